// ===== sv/vxpb_pkg.sv =====
package vxpb_pkg;

    // One input beat: addresses and network identifier for one probe frame
    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [23:0] net_id;
    } item_beat_t;

    // One output beat: a single frame byte with its position
    typedef struct packed {
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic       last_byte;
    } frame_beat_t;

    // Frame geometry
    localparam int unsigned FRAME_BYTES = 50;
    localparam logic [5:0]  LAST_INDEX  = 6'(FRAME_BYTES - 1);

    // Register map (index taken from paddr[3])
    localparam logic REG_SOURCE_MAC = 1'b0;
    localparam logic REG_DEST_MAC   = 1'b1;

    // Register reset values
    localparam logic [47:0] SOURCE_MAC_RST = 48'h1122_3344_5566;
    localparam logic [47:0] DEST_MAC_RST   = 48'hEEFF_FFFF_FFFF;

    // Sum of the fixed 16-bit words of the IPv4 header:
    // 4500 + 001C + 0001 + 0000 + 4001 + 0000
    localparam logic [15:0] IP_CKS_BASE = 16'h851E;

endpackage

// ===== sv/vxlan_probe_packet_builder.sv =====
// Channel   | Dir | Handshake                     | Beat
// ----------+-----+-------------------------------+--------------------------------
// item      | in  | item_valid / item_ready       | vxpb_pkg::item_beat_t
// frame     | out | frame_valid / frame_ready     | vxpb_pkg::frame_beat_t
// APB       | in  | psel, penable, pwrite, pready | paddr[3:0], pwdata/prdata 64b
//
// Each item yields 50 frame beats, one per cycle when the sink is ready, and a
// pending item's frame follows the last beat back to back. The first beat passes
// the pending slot, the active frame registers and the output register.
// One further item is buffered while a frame is being sent.
// rst_n clears all control state and loads the MAC registers' reset values.
// A stall on frame_ready freezes the output register and the byte counter.
module vxlan_probe_packet_builder (
    input  logic                  clk,
    input  logic                  rst_n,
    // item channel
    input  logic                  item_valid,
    output logic                  item_ready,
    input  vxpb_pkg::item_beat_t  item,
    // frame channel
    output logic                  frame_valid,
    input  logic                  frame_ready,
    output vxpb_pkg::frame_beat_t frame_beat,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);

    // Configuration registers
    logic [47:0] source_mac_reg;
    logic [47:0] dest_mac_reg;

    // Pending item slot
    logic                 pend_vld_reg;
    vxpb_pkg::item_beat_t pend_reg;

    // Active frame
    logic                 act_vld_reg;
    logic [31:0]          act_sip_reg;
    logic [31:0]          act_dip_reg;
    logic [23:0]          act_vni_reg;
    logic [15:0]          act_cks_reg;
    logic [5:0]           cnt_reg;

    // Output register
    logic                  out_vld_reg;
    vxpb_pkg::frame_beat_t out_reg;
    vxpb_pkg::frame_beat_t out_next;

    logic        cfg_wr;
    logic        adv;
    logic        emit;
    logic        finish;
    logic        load_act;
    logic        item_acc;
    logic [18:0] cks_sum;
    logic [16:0] cks_fold;
    logic [15:0] cks_next;
    logic [7:0]  byte_sel;

    // APB decode
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        if (paddr[3] == vxpb_pkg::REG_DEST_MAC)
        begin
            prdata = {16'h0000, dest_mac_reg};
        end
        else
        begin
            prdata = {16'h0000, source_mac_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_mac_reg <= vxpb_pkg::SOURCE_MAC_RST;
            dest_mac_reg   <= vxpb_pkg::DEST_MAC_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[3] == vxpb_pkg::REG_DEST_MAC)
            begin
                dest_mac_reg <= pwdata[47:0];
            end
            else
            begin
                source_mac_reg <= pwdata[47:0];
            end
        end
    end

    // Flow control
    assign adv        = !out_vld_reg || frame_ready;
    assign emit       = adv && act_vld_reg;
    assign finish     = emit && (cnt_reg == vxpb_pkg::LAST_INDEX);
    assign load_act   = pend_vld_reg && (!act_vld_reg || finish);
    assign item_ready = !pend_vld_reg;
    assign item_acc   = item_valid && item_ready;

    // IPv4 header checksum of the pending item, ones-complement fold
    always_comb
    begin
        cks_sum  = 19'(vxpb_pkg::IP_CKS_BASE)
                 + 19'(pend_reg.src_ip[31:16]) + 19'(pend_reg.src_ip[15:0])
                 + 19'(pend_reg.dst_ip[31:16]) + 19'(pend_reg.dst_ip[15:0]);
        cks_fold = 17'(cks_sum[18:16]) + 17'(cks_sum[15:0]);
        cks_next = ~(cks_fold[15:0] + 16'(cks_fold[16]));
    end

    // Pending slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
        end
        else if (item_acc)
        begin
            pend_vld_reg <= 1'b1;
        end
        else if (load_act)
        begin
            pend_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            pend_reg <= item;
        end
    end

    // Active frame control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_vld_reg <= 1'b0;
            cnt_reg     <= 6'd0;
        end
        else if (load_act)
        begin
            act_vld_reg <= 1'b1;
            cnt_reg     <= 6'd0;
        end
        else if (finish)
        begin
            act_vld_reg <= 1'b0;
            cnt_reg     <= 6'd0;
        end
        else if (emit)
        begin
            cnt_reg <= cnt_reg + 6'd1;
        end
    end

    // Active frame payload
    always_ff @(posedge clk)
    begin
        if (load_act)
        begin
            act_sip_reg <= pend_reg.src_ip;
            act_dip_reg <= pend_reg.dst_ip;
            act_vni_reg <= pend_reg.net_id;
            act_cks_reg <= cks_next;
        end
    end

    // Byte selection by position
    always_comb
    begin
        case (cnt_reg)
            6'd0:  byte_sel = 8'h08;
            6'd4:  byte_sel = act_vni_reg[23:16];
            6'd5:  byte_sel = act_vni_reg[15:8];
            6'd6:  byte_sel = act_vni_reg[7:0];
            6'd8:  byte_sel = dest_mac_reg[47:40];
            6'd9:  byte_sel = dest_mac_reg[39:32];
            6'd10: byte_sel = dest_mac_reg[31:24];
            6'd11: byte_sel = dest_mac_reg[23:16];
            6'd12: byte_sel = dest_mac_reg[15:8];
            6'd13: byte_sel = dest_mac_reg[7:0];
            6'd14: byte_sel = source_mac_reg[47:40];
            6'd15: byte_sel = source_mac_reg[39:32];
            6'd16: byte_sel = source_mac_reg[31:24];
            6'd17: byte_sel = source_mac_reg[23:16];
            6'd18: byte_sel = source_mac_reg[15:8];
            6'd19: byte_sel = source_mac_reg[7:0];
            6'd20: byte_sel = 8'h08;
            6'd22: byte_sel = 8'h45;
            6'd25: byte_sel = 8'h1C;
            6'd27: byte_sel = 8'h01;
            6'd30: byte_sel = 8'h40;
            6'd31: byte_sel = 8'h01;
            6'd32: byte_sel = act_cks_reg[15:8];
            6'd33: byte_sel = act_cks_reg[7:0];
            6'd34: byte_sel = act_sip_reg[31:24];
            6'd35: byte_sel = act_sip_reg[23:16];
            6'd36: byte_sel = act_sip_reg[15:8];
            6'd37: byte_sel = act_sip_reg[7:0];
            6'd38: byte_sel = act_dip_reg[31:24];
            6'd39: byte_sel = act_dip_reg[23:16];
            6'd40: byte_sel = act_dip_reg[15:8];
            6'd41: byte_sel = act_dip_reg[7:0];
            6'd42: byte_sel = 8'h08;
            6'd44: byte_sel = 8'hF7;
            6'd45: byte_sel = 8'hFF;
            default: byte_sel = 8'h00;
        endcase
    end

    always_comb
    begin
        out_next.data_byte  = byte_sel;
        out_next.byte_index = cnt_reg;
        out_next.last_byte  = (cnt_reg == vxpb_pkg::LAST_INDEX);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= act_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    assign frame_valid = out_vld_reg;
    assign frame_beat  = out_reg;

    // Checks
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_reg.last_byte == (out_reg.byte_index == vxpb_pkg::LAST_INDEX)))
        else $error("last_byte does not match byte_index");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        act_vld_reg |-> (cnt_reg <= vxpb_pkg::LAST_INDEX))
        else $error("byte counter out of range");

    a_frame_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_reg.last_byte)
            |-> (act_vld_reg && (cnt_reg == out_reg.byte_index + 6'd1)))
        else $error("frame broken off before last byte");

endmodule

// ===== test/tb_vxlan_probe_packet_builder.sv =====
module tb_vxlan_probe_packet_builder;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no beat and no register access before the run is declared hung
    localparam int QUIET_LIMIT  = 3000;
    // leave a generous margin at the end
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 115;

    localparam logic [3:0] SOURCE_MAC_ADDR = {vxpb_pkg::REG_SOURCE_MAC, 3'b000};
    localparam logic [3:0] DEST_MAC_ADDR   = {vxpb_pkg::REG_DEST_MAC, 3'b000};

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  item_valid  = 1'b0;
    logic                  item_ready;
    vxpb_pkg::item_beat_t  item        = '0;
    logic                  frame_valid;
    logic                  frame_ready = 1'b0;
    vxpb_pkg::frame_beat_t frame_beat;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [3:0]            paddr       = '0;
    logic [63:0]           pwdata      = '0;
    logic [63:0]           prdata;
    logic                  pready;

    vxlan_probe_packet_builder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_beat  (frame_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 clk = ~clk;

    vxpb_pkg::item_beat_t  probes_pending[$];
    vxpb_pkg::frame_beat_t frame_bytes_due[$];

    // local copy of the MAC registers, reset values
    logic [47:0] cur_source_mac = 48'h1122_3344_5566;
    logic [47:0] cur_dest_mac   = 48'hEEFF_FFFF_FFFF;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   fail_count     = 0;
    int   quiet_cycles   = 0;
    logic item_taken     = 1'b0;

    wire item_fire  = item_valid && item_ready;
    wire frame_fire = frame_valid && frame_ready;

    // Build the 50 bytes of one probe frame and queue them as expected beats
    function automatic void push_probe_frame(input vxpb_pkg::item_beat_t p);
        logic [18:0]           word_sum;
        logic [16:0]           folded;
        logic [15:0]           ip_cks;
        logic [399:0]          frame_bits;
        vxpb_pkg::frame_beat_t b;
        int                    k;
        // ones-complement sum of the IPv4 header words, checksum field as zero
        word_sum = 19'h4500 + 19'h001C + 19'h0001 + 19'h4001
                 + p.src_ip[31:16] + p.src_ip[15:0]
                 + p.dst_ip[31:16] + p.dst_ip[15:0];
        folded   = word_sum[15:0] + word_sum[18:16];
        folded   = folded[15:0] + folded[16];
        ip_cks   = ~folded[15:0];
        frame_bits = {8'h08, 8'h00, 8'h00, 8'h00, p.net_id, 8'h00,
                      cur_dest_mac, cur_source_mac, 16'h0800,
                      16'h4500, 16'h001C, 16'h0001, 16'h0000, 16'h4001, ip_cks,
                      p.src_ip, p.dst_ip,
                      16'h0800, 16'hF7FF, 32'h0000_0000};
        for (k = 0; k < vxpb_pkg::FRAME_BYTES; k++)
        begin
            b.data_byte  = frame_bits[399 - 8 * k -: 8];
            b.byte_index = 6'(k);
            b.last_byte  = (k == vxpb_pkg::FRAME_BYTES - 1);
            frame_bytes_due.push_back(b);
        end
    endfunction

    // Input side: note accepted items and predict their frames
    always @(posedge clk)
    begin
        if (!rst_n)
            item_taken <= 1'b0;
        else
        begin
            item_taken <= item_fire;
            if (item_fire)
                push_probe_frame(item);
        end
    end

    // Driver: new item only once the previous one has been taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            frame_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (!item_valid || item_taken)
            begin
                if (probes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item_valid <= 1'b1;
                    item       <= probes_pending.pop_front();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Monitor: each frame beat against the oldest expected byte
    always @(posedge clk)
    begin : frame_check
        vxpb_pkg::frame_beat_t want;
        if (rst_n && frame_fire)
        begin
            if (frame_bytes_due.size() == 0)
            begin
                $display("%0t: unexpected frame beat, actual %h", $time, frame_beat);
                fail_count++;
            end
            else
            begin
                want = frame_bytes_due.pop_front();
                if (frame_beat.data_byte !== want.data_byte)
                begin
                    $display("%0t: data_byte expected %h actual %h (index %0d)",
                             $time, want.data_byte, frame_beat.data_byte, want.byte_index);
                    fail_count++;
                end
                if (frame_beat.byte_index !== want.byte_index)
                begin
                    $display("%0t: byte_index expected %0d actual %0d",
                             $time, want.byte_index, frame_beat.byte_index);
                    fail_count++;
                end
                if (frame_beat.last_byte !== want.last_byte)
                begin
                    $display("%0t: last_byte expected %b actual %b (index %0d)",
                             $time, want.last_byte, frame_beat.last_byte, want.byte_index);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on a stalled run
    always @(posedge clk)
    begin
        if (!rst_n || item_fire || frame_fire || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // APB read, value checked at the end of the access phase
    task automatic mac_readback(input logic [3:0] addr, input logic [47:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[47:0] !== want)
        begin
            $display("%0t: register at %h expected %h actual %h",
                     $time, addr, want, prdata[47:0]);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // APB write, then read it back; only the low 48 bits are kept
    task automatic mac_write(input logic [3:0] addr, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[3] == vxpb_pkg::REG_SOURCE_MAC)
            cur_source_mac = value[47:0];
        else
            cur_dest_mac = value[47:0];
        mac_readback(addr,
                     (addr[3] == vxpb_pkg::REG_SOURCE_MAC) ? cur_source_mac : cur_dest_mac);
    endtask

    // Random items, with all-zero and all-one fields mixed in now and then
    task automatic queue_random_probes(input int count);
        vxpb_pkg::item_beat_t p;
        int                   i;
        for (i = 0; i < count; i++)
        begin
            case ($urandom_range(7))
                0:       p.src_ip = '0;
                1:       p.src_ip = '1;
                default: p.src_ip = $urandom;
            endcase
            case ($urandom_range(7))
                0:       p.dst_ip = '0;
                1:       p.dst_ip = '1;
                default: p.dst_ip = $urandom;
            endcase
            case ($urandom_range(7))
                0:       p.net_id = '0;
                1:       p.net_id = '1;
                default: p.net_id = 24'($urandom);
            endcase
            probes_pending.push_back(p);
        end
    endtask

    // Block idle: nothing queued, nothing in flight, all frames seen.
    // Sampled on the rising edge, where the driver's last update has settled.
    task automatic wait_until_idle();
        while (probes_pending.size() != 0 || item_valid || frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin : stimulus
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset values of the MAC registers
        mac_readback(SOURCE_MAC_ADDR, 48'h1122_3344_5566);
        mac_readback(DEST_MAC_ADDR, 48'hEEFF_FFFF_FFFF);

        // directed: field extremes and checksum corner cases, reset MACs
        send_idle_pct  = 25;
        recv_stall_pct = 81;
        probes_pending.push_back('{32'h0000_0000, 32'h0000_0000, 24'h00_0000});
        probes_pending.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF});
        probes_pending.push_back('{32'hFFFF_FFFF, 32'h0000_0000, 24'h00_0000});
        probes_pending.push_back('{32'h0000_0000, 32'hFFFF_FFFF, 24'hFF_FFFF});
        probes_pending.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 24'hAA_AAAA});
        probes_pending.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 24'h55_5555});
        // header sum of exactly FFFF: checksum comes out as zero
        probes_pending.push_back('{32'h7AE1_0000, 32'h0000_0000, 24'h80_0001});
        // sum of 10000: one end-around carry
        probes_pending.push_back('{32'h7AE2_0000, 32'h0000_0000, 24'h00_0001});
        // first fold overflows again: two end-around carries
        probes_pending.push_back('{32'hFFFF_FFFF, 32'hFFFF_7AE4, 24'h00_0001});
        probes_pending.push_back('{32'h0A00_0001, 32'h0A00_0002, 24'h00_1234});
        probes_pending.push_back('{32'hC0A8_0001, 32'h0808_0808, 24'hFF_FFFE});
        probes_pending.push_back('{32'h8000_0001, 32'h0000_8000, 24'h7F_FFFF});
        wait_until_idle();

        // phase 1: MAC extremes, sender idles lightly, receiver stalls hard
        mac_write(SOURCE_MAC_ADDR, {16'($urandom), 48'h0000_0000_0000});
        mac_write(DEST_MAC_ADDR, {16'($urandom), 48'hFFFF_FFFF_FFFF});
        queue_random_probes(RANDOM_ITEMS);
        wait_until_idle();

        // phase 2: MACs swapped over, idling the other way round
        send_idle_pct  = 81;
        recv_stall_pct = 25;
        mac_write(SOURCE_MAC_ADDR, {16'($urandom), 48'hFFFF_FFFF_FFFF});
        mac_write(DEST_MAC_ADDR, {16'($urandom), 48'h0000_0000_0000});
        queue_random_probes(RANDOM_ITEMS);
        wait_until_idle();

        // phase 3: random MACs, back-to-back items at full rate
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mac_write(SOURCE_MAC_ADDR, {$urandom, $urandom});
        mac_write(DEST_MAC_ADDR, {$urandom, $urandom});
        queue_random_probes(RANDOM_ITEMS);
        wait_until_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
